// File: rtl/vmm_pkg.sv
// Shared types and constants for the video memory mirroring map.
// Used by every module in rtl/; depends on nothing else.
package vmm_pkg;

	localparam int PAL_AW    = 5;
	localparam int PAL_DW    = 6;
	localparam int PAT_AW    = 13;
	localparam int PAT_BYTES = 8192;
	localparam int NT_MAP_W  = 11;
	localparam int NT_OFF_W  = 10;

	localparam logic [15:0] FOLD_LO   = 16'h3000;
	localparam logic [15:0] FOLD_HI   = 16'h3EFF;
	localparam logic [15:0] FOLD_STEP = 16'h1000;
	localparam logic [15:0] NT_BASE   = 16'h2000;

	typedef enum logic [2:0] {
		ACT_NT_RD  = 3'd0,
		ACT_NT_WR  = 3'd1,
		ACT_PAL_RD = 3'd2,
		ACT_PAL_WR = 3'd3,
		ACT_PAT_RD = 3'd4,
		ACT_PAT_WR = 3'd5
	} action_t;

	typedef enum logic [2:0] {
		MIR_HORZ      = 3'd0,
		MIR_VERT      = 3'd1,
		MIR_SINGLE_LO = 3'd2,
		MIR_SINGLE_HI = 3'd3,
		MIR_FOUR      = 3'd4
	} mirror_t;

	typedef enum logic [1:0] {
		SEL_NONE = 2'd0,
		SEL_NT   = 2'd1,
		SEL_PAL  = 2'd2,
		SEL_PAT  = 2'd3
	} sel_t;

	typedef struct packed {
		logic                nt_we;
		logic                pal_we;
		logic                pat_we;
		logic [7:0]          wdata;
		logic [NT_MAP_W-1:0] nt_idx;
		logic [PAL_AW-1:0]   pal_idx;
		logic [PAT_AW-1:0]   pat_idx;
	} store_req_t;

endpackage

// File: rtl/vmm_nt_map.sv
// Nametable address mapping: folds, splits and mirrors a 16-bit address
// into a physical byte index. Depends on vmm_pkg.
module vmm_nt_map
	import vmm_pkg::*;
(
	input  logic [15:0]         address,
	input  logic [2:0]          mirror_mode,
	output logic [NT_MAP_W-1:0] nt_idx
);

	logic [15:0]         folded;
	logic [15:0]         rel;
	logic [1:0]          table_sel;
	logic                page;

	always_comb begin
		if (address >= FOLD_LO && address <= FOLD_HI) begin
			folded = address - FOLD_STEP;
		end else begin
			folded = address;
		end
		rel       = folded - NT_BASE;
		table_sel = rel[NT_OFF_W+1:NT_OFF_W];
		unique case (mirror_mode)
			MIR_HORZ:      page = table_sel[1];
			MIR_VERT:      page = table_sel[0];
			MIR_SINGLE_LO: page = 1'b0;
			MIR_SINGLE_HI: page = 1'b1;
			MIR_FOUR:      page = table_sel[0];
			default:       page = 1'b0;
		endcase
		// Page plus offset always lies below two pages, inside the store.
		nt_idx = {page, rel[NT_OFF_W-1:0]};
	end

endmodule

// File: rtl/vmm_stores.sv
// The three video stores with registered reads, plus the clearing pass that
// loads the nametable and pattern reset contents after reset. Depends on vmm_pkg.
module vmm_stores
	import vmm_pkg::*;
#(
	parameter int NAMETABLE_BYTES = 2048
)
(
	input  logic              clk,
	input  logic              arst_n,
	input  store_req_t        req,
	output logic              clearing,
	output logic [7:0]        nt_rdata,
	output logic [PAL_DW-1:0] pal_rdata,
	output logic [7:0]        pat_rdata
);

	localparam int NT_AW = $clog2(NAMETABLE_BYTES);
	localparam logic [PAT_AW:0] NT_LIMIT = (PAT_AW + 1)'(NAMETABLE_BYTES);
	localparam logic [PAT_AW-1:0] CLR_LAST = PAT_AW'(PAT_BYTES - 1);

	logic [7:0]        nt_mem [NAMETABLE_BYTES];
	logic [7:0]        pat_mem [PAT_BYTES];
	logic [PAL_DW-1:0] palette_q [2**PAL_AW];

	logic              clear_q;
	logic [PAT_AW-1:0] clr_cnt_q;

	logic              nt_we;
	logic [NT_AW-1:0]  nt_addr;
	logic [7:0]        nt_wdata;
	logic              pat_we;
	logic [PAT_AW-1:0] pat_addr;
	logic [7:0]        pat_wdata;

	assign clearing = clear_q;

	// The pattern store is the deeper one, so its sweep sets the pass length.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_q   <= 1'b1;
			clr_cnt_q <= '0;
		end else if (clear_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == CLR_LAST) begin
				clear_q <= 1'b0;
			end
		end
	end

	always_comb begin
		if (clear_q) begin
			nt_we     = ({1'b0, clr_cnt_q} < NT_LIMIT);
			nt_addr   = NT_AW'(clr_cnt_q);
			nt_wdata  = '0;
			pat_we    = 1'b1;
			pat_addr  = clr_cnt_q;
			pat_wdata = clr_cnt_q[7:0];
		end else begin
			nt_we     = req.nt_we;
			nt_addr   = NT_AW'(req.nt_idx);
			nt_wdata  = req.wdata;
			pat_we    = req.pat_we;
			pat_addr  = req.pat_idx;
			pat_wdata = req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (nt_we) begin
			nt_mem[nt_addr] <= nt_wdata;
		end
		nt_rdata <= nt_mem[nt_addr];
	end

	always_ff @(posedge clk) begin
		if (pat_we) begin
			pat_mem[pat_addr] <= pat_wdata;
		end
		pat_rdata <= pat_mem[pat_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 2**PAL_AW; i++) begin
				palette_q[i] <= '0;
			end
		end else if (req.pal_we) begin
			palette_q[req.pal_idx] <= req.wdata[PAL_DW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		pal_rdata <= palette_q[req.pal_idx];
	end

endmodule

// File: rtl/video_memory_mirroring_map_core.sv
// Top level of the video memory mirroring map: request register, action
// decode, mirror register and result select. Uses vmm_pkg, vmm_nt_map, vmm_stores.
//
//  channel   signals                               direction
//  request   start, busy, action, address,
//            write_byte                            in (busy out)
//  result    done, read_byte                       out
//  config    cfg_valid, cfg_ready, cfg_data        in (cfg_ready out)
//
// A request is taken at every edge where start is high and busy is low, one
// per cycle; its result shows on read_byte with done after the request
// register and the registered store read. After reset busy stays high while
// the clearing pass loads the nametable and pattern stores, for as long as the
// pattern store sweep runs. The result side cannot stall, so no request is
// ever held off after the pass. The mirror register takes writes in any cycle.
module video_memory_mirroring_map_core
	import vmm_pkg::*;
#(
	parameter int NAMETABLE_BYTES = 2048
)
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  action,
	input  logic [15:0] address,
	input  logic [7:0]  write_byte,
	output logic        done,
	output logic [7:0]  read_byte,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_data
);

	logic        valid_s1;
	logic [2:0]  action_s1;
	logic [15:0] address_s1;
	logic [7:0]  write_byte_s1;
	logic        valid_s2;
	sel_t        sel_s2;

	logic [2:0]          mirror_q;
	logic                clearing;
	logic [NT_MAP_W-1:0] nt_idx;
	store_req_t          req;
	sel_t                sel;
	logic [7:0]          nt_rdata;
	logic [PAL_DW-1:0]   pal_rdata;
	logic [7:0]          pat_rdata;

	assign busy      = clearing;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mirror_q <= MIR_HORZ;
		end else if (cfg_valid && cfg_ready) begin
			mirror_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			sel_s2   <= SEL_NONE;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			sel_s2   <= sel;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			action_s1     <= action;
			address_s1    <= address;
			write_byte_s1 <= write_byte;
		end
	end

	vmm_nt_map u_nt_map (
		.address     (address_s1),
		.mirror_mode (mirror_q),
		.nt_idx      (nt_idx)
	);

	always_comb begin
		req.nt_we   = 1'b0;
		req.pal_we  = 1'b0;
		req.pat_we  = 1'b0;
		req.wdata   = write_byte_s1;
		req.nt_idx  = nt_idx;
		req.pal_idx = address_s1[PAL_AW-1:0];
		req.pat_idx = address_s1[PAT_AW-1:0];
		sel         = SEL_NONE;
		if (valid_s1) begin
			unique case (action_s1)
				ACT_NT_RD:  sel = SEL_NT;
				ACT_NT_WR:  req.nt_we = 1'b1;
				ACT_PAL_RD: sel = SEL_PAL;
				ACT_PAL_WR: req.pal_we = 1'b1;
				ACT_PAT_RD: sel = SEL_PAT;
				ACT_PAT_WR: req.pat_we = 1'b1;
				// Unassigned action codes touch nothing and read back zero.
				default:    sel = SEL_NONE;
			endcase
		end
	end

	vmm_stores #(
		.NAMETABLE_BYTES (NAMETABLE_BYTES)
	) u_stores (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.clearing  (clearing),
		.nt_rdata  (nt_rdata),
		.pal_rdata (pal_rdata),
		.pat_rdata (pat_rdata)
	);

	assign done = valid_s2;

	always_comb begin
		unique case (sel_s2)
			SEL_NT:   read_byte = nt_rdata;
			SEL_PAL:  read_byte = 8'(pal_rdata);
			SEL_PAT:  read_byte = pat_rdata;
			default:  read_byte = '0;
		endcase
	end

endmodule

// File: dv/testbench.sv
// Self-checking testbench for video_memory_mirroring_map_core: nametable mirroring,
// palette and pattern accesses checked against a predictor of the three stores.
// Depends on rtl/vmm_pkg.sv and rtl/video_memory_mirroring_map_core.sv.
module testbench
	import vmm_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NT_BYTES = 2048;
	localparam int NT_PAGE  = 1024;
	localparam int SETTLE   = 6;

	// Codes outside the package enums.
	localparam logic [2:0] ACT_UNUSED_6 = 3'd6;
	localparam logic [2:0] ACT_UNUSED_7 = 3'd7;
	localparam logic [2:0] MIR_UNUSED_5 = 3'd5;
	localparam logic [2:0] MIR_UNUSED_7 = 3'd7;

	typedef struct {
		logic [2:0]  act;
		logic [15:0] addr;
		logic [7:0]  rd;
	} read_expect_t;

	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        start      = 1'b0;
	logic        busy;
	logic [2:0]  action     = 3'd0;
	logic [15:0] address    = 16'h0000;
	logic [7:0]  write_byte = 8'h00;
	logic        done;
	logic [7:0]  read_byte;
	logic        cfg_valid  = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_data   = 3'd0;

	video_memory_mirroring_map_core #(
		.NAMETABLE_BYTES(NT_BYTES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.action(action),
		.address(address),
		.write_byte(write_byte),
		.done(done),
		.read_byte(read_byte),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	// Predictor state.
	logic [7:0]   nt_mem  [NT_BYTES];
	logic [5:0]   pal_mem [32];
	logic [7:0]   pat_mem [PAT_BYTES];
	logic [2:0]   mirror_cfg = MIR_HORZ;

	read_expect_t expected_reads [$];
	logic [15:0]  hot_addr [16];
	bit           gaps_on = 1'b1;
	int           errors = 0;
	int           n_nt = 0, n_pal = 0, n_pat = 0, n_unused = 0, n_modes = 0;

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#3ms;
		$display("Timeout at %0t with %0d results outstanding", $realtime, expected_reads.size());
		$display("Mismatches found");
		$finish;
	end

	function automatic int nt_slot(input logic [15:0] addr);
		logic [15:0] a;
		logic [15:0] rel;
		logic [1:0]  tbl;
		int          pg;
		a = addr;
		if (a >= FOLD_LO && a <= FOLD_HI)
			a = a - FOLD_STEP;
		rel = a - NT_BASE;
		tbl = rel[11:10];
		case (mirror_cfg)
			MIR_HORZ:            pg = int'(tbl[1]);
			MIR_VERT, MIR_FOUR:  pg = int'(tbl[0]);
			MIR_SINGLE_LO:       pg = 0;
			MIR_SINGLE_HI:       pg = 1;
			default:             pg = 0;
		endcase
		return (pg * NT_PAGE + int'(rel[9:0])) % NT_BYTES;
	endfunction

	// Applies one access to the predicted stores and returns the byte read.
	function automatic logic [7:0] mem_access(input logic [2:0] act, input logic [15:0] addr,
			input logic [7:0] wb);
		int         ni;
		logic [7:0] rd;
		ni = nt_slot(addr);
		rd = 8'h00;
		case (act)
			ACT_NT_RD:  rd = nt_mem[ni];
			ACT_NT_WR:  nt_mem[ni] = wb;
			ACT_PAL_RD: rd = {2'b00, pal_mem[addr[4:0]]};
			ACT_PAL_WR: pal_mem[addr[4:0]] = wb[5:0];
			ACT_PAT_RD: rd = pat_mem[addr[12:0]];
			ACT_PAT_WR: pat_mem[addr[12:0]] = wb;
			default: ;
		endcase
		return rd;
	endfunction

	task automatic send_access(input logic [2:0] act, input logic [15:0] addr,
			input logic [7:0] wb);
		int           gap;
		read_expect_t e;
		gap = gaps_on ? $urandom_range(0, 19) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start      <= 1'b1;
		action     <= act;
		address    <= addr;
		write_byte <= wb;
		do @(posedge clk); while (busy !== 1'b0);
		e.act  = act;
		e.addr = addr;
		e.rd   = mem_access(act, addr, wb);
		expected_reads.insert(expected_reads.size(), e);
		case (act)
			ACT_NT_RD, ACT_NT_WR:   n_nt++;
			ACT_PAL_RD, ACT_PAL_WR: n_pal++;
			ACT_PAT_RD, ACT_PAT_WR: n_pat++;
			default:                n_unused++;
		endcase
	endtask

	// Stops sending and waits until every request has produced its result.
	task automatic finish_phase();
		start <= 1'b0;
		while (expected_reads.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_mirror(input logic [2:0] mode);
		cfg_valid <= 1'b1;
		cfg_data  <= mode;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid  <= 1'b0;
		mirror_cfg = mode;
		n_modes++;
	endtask

	// Hot addresses share a few offsets across all four logical tables, so that
	// mirrored aliases and read-after-write hits happen often.
	task automatic refresh_hot_addrs();
		logic [9:0] offs [4];
		offs[0] = 10'h000;
		offs[1] = 10'h3FF;
		offs[2] = 10'($urandom_range(0, 1023));
		offs[3] = 10'($urandom_range(0, 1023));
		for (int i = 0; i < 16; i++) begin
			hot_addr[i] = NT_BASE + 16'(i % 4) * 16'h0400 + 16'(offs[i / 4]);
			if ($urandom_range(0, 2) == 0)
				hot_addr[i] = hot_addr[i] + FOLD_STEP;
		end
	endtask

	task automatic random_access();
		int          r;
		logic [2:0]  act;
		logic [15:0] addr;
		r = $urandom_range(0, 99);
		if (r < 45)
			act = $urandom_range(0, 1) ? ACT_NT_WR : ACT_NT_RD;
		else if (r < 65)
			act = $urandom_range(0, 1) ? ACT_PAL_WR : ACT_PAL_RD;
		else if (r < 95)
			act = $urandom_range(0, 1) ? ACT_PAT_WR : ACT_PAT_RD;
		else
			act = $urandom_range(0, 1) ? ACT_UNUSED_7 : ACT_UNUSED_6;
		r = $urandom_range(0, 9);
		if (r < 6)
			addr = hot_addr[$urandom_range(0, 15)];
		else if (r < 8)
			addr = NT_BASE + 16'($urandom_range(0, 8191));
		else
			addr = 16'($urandom_range(0, 65535));
		send_access(act, addr, 8'($urandom_range(0, 255)));
	endtask

	// Results are checked in request order.
	always @(posedge clk) begin
		read_expect_t e;
		if (arst_n && done === 1'b1) begin
			if (expected_reads.size() == 0) begin
				$display("%0t: unexpected result %02h with no request pending",
					$realtime, read_byte);
				errors++;
			end else begin
				e = expected_reads.pop_front();
				if (read_byte !== e.rd) begin
					$display("%0t: read_byte mismatch, action %0d address %04h: expected %02h, got %02h",
						$realtime, e.act, e.addr, e.rd, read_byte);
					errors++;
				end
			end
		end
	end

	task automatic check_reset_contents();
		send_access(ACT_NT_RD, 16'h2000, 8'h00);
		send_access(ACT_NT_RD, 16'h2FFF, 8'h00);
		send_access(ACT_PAL_RD, 16'h3F00, 8'h00);
		send_access(ACT_PAL_RD, 16'h3F1F, 8'h00);
		send_access(ACT_PAT_RD, 16'h0000, 8'h00);
		send_access(ACT_PAT_RD, 16'h1FFF, 8'h00);
		send_access(ACT_PAT_RD, 16'h0123, 8'h00);
		finish_phase();
	endtask

	task automatic check_directed_accesses();
		// Mirror and fold boundaries, including addresses outside the nametable window.
		send_access(ACT_NT_WR, 16'h2000, 8'hFF);
		send_access(ACT_NT_RD, 16'h2400, 8'h00);
		send_access(ACT_NT_RD, 16'h2800, 8'h00);
		send_access(ACT_NT_WR, 16'h3EFF, 8'hA5);
		send_access(ACT_NT_RD, 16'h2EFF, 8'h00);
		send_access(ACT_NT_RD, 16'h3F00, 8'h00);
		send_access(ACT_NT_WR, 16'hFFFF, 8'h5A);
		send_access(ACT_NT_RD, 16'h1FFF, 8'h00);
		send_access(ACT_NT_RD, 16'h0000, 8'h00);
		send_access(ACT_NT_RD, 16'h3000, 8'h00);
		// Palette writes keep only six bits.
		send_access(ACT_PAL_WR, 16'h3F1F, 8'hFF);
		send_access(ACT_PAL_RD, 16'h001F, 8'h00);
		send_access(ACT_PAL_WR, 16'hFFE0, 8'hC0);
		send_access(ACT_PAL_RD, 16'h3F00, 8'h00);
		send_access(ACT_PAL_WR, 16'h3F05, 8'h2A);
		send_access(ACT_PAL_RD, 16'h3F05, 8'hFF);
		send_access(ACT_PAT_WR, 16'h1FFF, 8'h00);
		send_access(ACT_PAT_RD, 16'hFFFF, 8'h00);
		send_access(ACT_PAT_WR, 16'h0000, 8'hFF);
		send_access(ACT_PAT_RD, 16'hE000, 8'h00);
		send_access(ACT_PAT_RD, 16'h1234, 8'h00);
		// Unused actions must leave every store alone.
		send_access(ACT_UNUSED_6, 16'h2000, 8'h11);
		send_access(ACT_UNUSED_7, 16'hFFFF, 8'hFF);
		send_access(ACT_NT_RD, 16'h2000, 8'h00);
		send_access(ACT_PAT_RD, 16'hFFFF, 8'h00);
		finish_phase();
	endtask

	task automatic check_mirror_modes();
		logic [9:0]  off;
		logic [15:0] addr;
		for (int m = 0; m < 8; m++) begin
			set_mirror(3'(m));
			off = 10'($urandom_range(0, 1023));
			for (int t = 0; t < 4; t++)
				send_access(ACT_NT_WR, NT_BASE + 16'(t) * 16'h0400 + 16'(off),
					8'($urandom_range(0, 255)));
			for (int t = 0; t < 4; t++) begin
				addr = NT_BASE + 16'(t) * 16'h0400 + 16'(off);
				if ($urandom_range(0, 1))
					addr = addr + FOLD_STEP;
				send_access(ACT_NT_RD, addr, 8'($urandom_range(0, 255)));
			end
			finish_phase();
		end
	endtask

	task automatic check_random_traffic();
		logic [2:0] mode;
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0:       mode = MIR_HORZ;
				1:       mode = MIR_UNUSED_7;
				2:       mode = MIR_FOUR;
				3:       mode = MIR_UNUSED_5;
				default: mode = 3'($urandom_range(0, 7));
			endcase
			set_mirror(mode);
			refresh_hot_addrs();
			gaps_on = (ph != 2);
			repeat (150) random_access();
			finish_phase();
		end
		gaps_on = 1'b1;
	endtask

	// Back-to-back requests, then a full drain before the next burst.
	task automatic check_burst_and_drain();
		set_mirror(MIR_VERT);
		refresh_hot_addrs();
		gaps_on = 1'b0;
		repeat (40) random_access();
		finish_phase();
		repeat (20) random_access();
		gaps_on = 1'b1;
		repeat (10) random_access();
		finish_phase();
	endtask

	initial begin
		for (int i = 0; i < NT_BYTES; i++)
			nt_mem[i] = 8'h00;
		for (int i = 0; i < 32; i++)
			pal_mem[i] = 6'h00;
		for (int i = 0; i < PAT_BYTES; i++)
			pat_mem[i] = 8'(i);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		check_reset_contents();
		check_directed_accesses();
		check_mirror_modes();
		check_random_traffic();
		check_burst_and_drain();

		$display("Ran %0d nametable, %0d palette, %0d pattern and %0d unused-action requests",
			n_nt, n_pal, n_pat, n_unused);
		$display("under %0d mirror register writes covering all eight mode codes", n_modes);
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
